// File: rtl/uf_pkg.sv
package uf_pkg;

  localparam int NUM_ELEMENTS_DEF = 1024;

  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int RANK_W = 4;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_MAKE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNION = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd2;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MADE       = 2'd1,
    ST_NOT_ROOT   = 2'd2,
    ST_NEVER_MADE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK_A,
    S_CHK_B,
    S_UWIN,
    S_WALK,
    S_COMP,
    S_DONE
  } state_t;

  // one table entry per element
  typedef struct packed {
    logic              made;
    logic              root;
    logic [IDX_W-1:0]  parent;
    logic [CNT_W-1:0]  size;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    status_t          status;
    logic [CNT_W-1:0] set_count;
    logic [CNT_W-1:0] set_size;
  } res_t;

endpackage

// File: rtl/uf_mem.sv
module uf_mem #(
  parameter int DEPTH = uf_pkg::NUM_ELEMENTS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  uf_pkg::entry_t wdata,
  input  logic [AW-1:0]  raddr,
  output uf_pkg::entry_t rdata
);

  uf_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/uf_core.sv
module uf_core #(
  parameter int NUM_ELEMENTS = uf_pkg::NUM_ELEMENTS_DEF,
  localparam int AW = $clog2(NUM_ELEMENTS)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [uf_pkg::MODE_W-1:0]      in_mode,
  input  logic [uf_pkg::IDX_W-1:0]       in_index_a,
  input  logic [uf_pkg::IDX_W-1:0]       in_index_b,
  output logic                           res_valid,
  input  logic                           res_ready,
  output uf_pkg::res_t                   res,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output uf_pkg::entry_t                 mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  input  uf_pkg::entry_t                 mem_rdata
);

  localparam logic [AW-1:0] LAST = AW'(NUM_ELEMENTS - 1);

  uf_pkg::state_t state, state_next;

  logic [AW-1:0]                 clr_cnt;
  logic [uf_pkg::MODE_W-1:0]     mode_q;
  logic [uf_pkg::IDX_W-1:0]      idx_a, idx_b, cur, res_index;
  uf_pkg::entry_t                ent_a, win_ent;
  logic [AW-1:0]                 win_addr;
  uf_pkg::status_t               res_status;
  logic [uf_pkg::CNT_W-1:0]      res_size, count;

  uf_pkg::entry_t                rd;
  logic                          a_in_range, b_in_range, rd_is_root, parent_oor;
  logic                          make_ok, ua_ok, fa_ok, ub_ok, same, a_loses, tie;
  logic                          w_stop, c_stop;
  logic [uf_pkg::CNT_W-1:0]      sum;
  logic [AW-1:0]                 lose_addr, win_addr_d;
  uf_pkg::entry_t                lose_ent, win_ent_d, made_ent, comp_ent;
  logic [uf_pkg::IDX_W-1:0]      win_idx;

  assign rd = mem_rdata;

  always_comb begin
    a_in_range = 32'(idx_a) < NUM_ELEMENTS;
    b_in_range = 32'(idx_b) < NUM_ELEMENTS;
    rd_is_root = rd.made & rd.root;
    parent_oor = 32'(rd.parent) >= NUM_ELEMENTS;
    make_ok    = a_in_range & ~rd.made;
    ua_ok      = a_in_range & rd_is_root;
    fa_ok      = a_in_range & rd.made;
    ub_ok      = b_in_range & rd_is_root;
    same       = idx_a == idx_b;
    a_loses    = ent_a.rank < rd.rank;
    tie        = ent_a.rank == rd.rank;
    w_stop     = rd.root | parent_oor;
    c_stop     = (cur == res_index) | rd.root;
    sum        = ent_a.size + rd.size;

    made_ent        = '0;
    made_ent.made   = 1'b1;
    made_ent.root   = 1'b1;
    made_ent.size   = uf_pkg::CNT_W'(1);
    made_ent.rank   = uf_pkg::RANK_W'(1);

    comp_ent        = rd;
    comp_ent.parent = res_index;

    if (a_loses) begin
      lose_addr       = AW'(idx_a);
      lose_ent        = ent_a;
      lose_ent.root   = 1'b0;
      lose_ent.parent = idx_b;
      win_addr_d      = AW'(idx_b);
      win_ent_d       = rd;
      win_ent_d.size  = sum;
      win_idx         = idx_b;
    end else begin
      lose_addr       = AW'(idx_b);
      lose_ent        = rd;
      lose_ent.root   = 1'b0;
      lose_ent.parent = idx_a;
      win_addr_d      = AW'(idx_a);
      win_ent_d       = ent_a;
      win_ent_d.size  = sum;
      win_idx         = idx_a;
      if (tie && ent_a.rank < uf_pkg::RANK_MAX) begin
        win_ent_d.rank = ent_a.rank + uf_pkg::RANK_W'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      uf_pkg::S_CLEAR: if (clr_cnt == LAST) state_next = uf_pkg::S_IDLE;
      uf_pkg::S_IDLE:  if (in_valid) state_next = uf_pkg::S_CHK_A;
      uf_pkg::S_CHK_A: begin
        state_next = uf_pkg::S_DONE;
        if (mode_q == uf_pkg::MODE_UNION) begin
          if (ua_ok) state_next = uf_pkg::S_CHK_B;
        end else if (mode_q != uf_pkg::MODE_MAKE) begin
          if (fa_ok && !w_stop) state_next = uf_pkg::S_WALK;
        end
      end
      uf_pkg::S_CHK_B: begin
        state_next = (ub_ok && !same) ? uf_pkg::S_UWIN : uf_pkg::S_DONE;
      end
      uf_pkg::S_UWIN:  state_next = uf_pkg::S_DONE;
      uf_pkg::S_WALK:  if (w_stop) state_next = uf_pkg::S_COMP;
      uf_pkg::S_COMP:  if (c_stop || parent_oor) state_next = uf_pkg::S_DONE;
      uf_pkg::S_DONE:  if (res_ready) state_next = uf_pkg::S_IDLE;
      default:         state_next = uf_pkg::S_CLEAR;
    endcase
  end

  // outputs and memory port
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(cur);
    mem_wdata = comp_ent;
    mem_raddr = AW'(rd.parent);
    unique case (state)
      uf_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      uf_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = AW'(in_index_a);
      end
      uf_pkg::S_CHK_A: begin
        if (mode_q == uf_pkg::MODE_UNION) begin
          mem_raddr = AW'(idx_b);
        end else if (mode_q == uf_pkg::MODE_MAKE && make_ok) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_a);
          mem_wdata = made_ent;
        end
      end
      uf_pkg::S_CHK_B: begin
        if (ub_ok && !same) begin
          mem_we    = 1'b1;
          mem_waddr = lose_addr;
          mem_wdata = lose_ent;
        end
      end
      uf_pkg::S_UWIN: begin
        mem_we    = 1'b1;
        mem_waddr = win_addr;
        mem_wdata = win_ent;
      end
      uf_pkg::S_WALK: begin
        if (w_stop) mem_raddr = AW'(idx_a);
      end
      uf_pkg::S_COMP: begin
        mem_we = ~c_stop;
      end
      uf_pkg::S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= uf_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == uf_pkg::S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == uf_pkg::S_CHK_A && mode_q == uf_pkg::MODE_MAKE && make_ok) begin
      count <= count + uf_pkg::CNT_W'(1);
    end else if (state == uf_pkg::S_CHK_B && ub_ok && !same) begin
      count <= count - uf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      uf_pkg::S_IDLE: begin
        if (in_valid) begin
          mode_q <= in_mode;
          idx_a  <= in_index_a;
          idx_b  <= in_index_b;
        end
      end
      uf_pkg::S_CHK_A: begin
        ent_a     <= rd;
        res_index <= idx_a;
        res_size  <= '0;
        cur       <= rd.parent;
        if (mode_q == uf_pkg::MODE_MAKE) begin
          if (!a_in_range) begin
            res_status <= uf_pkg::ST_NEVER_MADE;
          end else if (rd.made) begin
            res_status <= uf_pkg::ST_MADE;
          end else begin
            res_status <= uf_pkg::ST_OK;
            res_size   <= uf_pkg::CNT_W'(1);
          end
        end else if (mode_q == uf_pkg::MODE_UNION) begin
          res_status <= uf_pkg::ST_NOT_ROOT;
        end else begin
          res_status <= fa_ok ? uf_pkg::ST_OK : uf_pkg::ST_NEVER_MADE;
          if (fa_ok && w_stop) res_size <= rd.size;
        end
      end
      uf_pkg::S_CHK_B: begin
        if (ub_ok) begin
          res_status <= uf_pkg::ST_OK;
          if (same) begin
            res_size <= ent_a.size;
          end else begin
            res_index <= win_idx;
            res_size  <= sum;
            win_addr  <= win_addr_d;
            win_ent   <= win_ent_d;
          end
        end
      end
      uf_pkg::S_WALK: begin
        if (w_stop) begin
          res_index <= cur;
          res_size  <= rd.size;
          cur       <= idx_a;
        end else begin
          cur <= rd.parent;
        end
      end
      uf_pkg::S_COMP: begin
        if (!c_stop) cur <= rd.parent;
      end
      default: ;
    endcase
  end

  assign res.result_index = res_index;
  assign res.status       = res_status;
  assign res.set_count    = count;
  assign res.set_size     = res_size;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("core took a word while busy");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    state != uf_pkg::S_CHK_A && state != uf_pkg::S_CHK_B |=> $stable(count))
    else $error("set count moved outside make or union");

  a_no_write_on_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !mem_we)
    else $error("table written while result is offered");

  a_error_size_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != uf_pkg::ST_OK |-> res.set_size == '0)
    else $error("error result carries a set size");

endmodule

// File: rtl/union_find_engine.sv
// Steps (accept to output word): make set, find at a root and first-operand errors check only
//   the first operand; union also checks the second and, unless it is no root or equals the
//   first, links the loser and then the winner; a find below the root reads one entry per hop up,
//   then reads and rewrites each path node onto the root. Throughput: one item at a time.
// Reset: rst is synchronous, active high; afterwards a clearing pass writes every table
//   entry, with s_tready low until it ends.
module union_find_engine #(
  parameter int NUM_ELEMENTS = uf_pkg::NUM_ELEMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // index_a[9:0], index_b[19:10], zero pad [23:20]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_index[9:0], set_count[20:10], set_size[31:21]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int AW = $clog2(NUM_ELEMENTS);

  logic           res_valid, res_ready;
  uf_pkg::res_t   res;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  uf_pkg::entry_t mem_wdata, mem_rdata;

  // Sequencer plus datapath; every table access goes through it.
  uf_core #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_index_a(s_tdata[9:0]),
    .in_index_b(s_tdata[19:10]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Element table: made and root flags, parent link, set size and rank per entry.
  uf_mem #(
    .DEPTH(NUM_ELEMENTS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Output register: take a new result whenever the slot is empty or being drained,
  // so the core can go back to idle while the consumer stalls on the last word.
  assign res_ready = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload holds until the next result is taken.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {res.set_size, res.set_count, res.result_index};
      m_tuser <= res.status;
    end
  end

endmodule

// File: test/union_find_checker.sv
`timescale 1ns / 100ps

module union_find_checker #(
  parameter int NUM_ELEMENTS = uf_pkg::NUM_ELEMENTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [23:0]             s_tdata,   // index_a, index_b, zero pad
  input  logic [1:0]              s_tuser,   // mode
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [31:0]             m_tdata,   // result_index, set_count, set_size
  input  logic [1:0]              m_tuser,   // status
  output int                      mismatches,
  output int                      outstanding,
  output int                      words_checked,
  output int                      error_words,
  output int                      links_made,
  output int                      deepest_walk,
  output logic [NUM_ELEMENTS-1:0] made_mask,
  output logic [NUM_ELEMENTS-1:0] root_mask
);

  // shadow of the disjoint-set table
  logic [NUM_ELEMENTS-1:0]    made_v;
  logic [NUM_ELEMENTS-1:0]    root_v;
  logic [uf_pkg::IDX_W-1:0]   parent_v [NUM_ELEMENTS];
  logic [uf_pkg::CNT_W-1:0]   size_v   [NUM_ELEMENTS];
  logic [uf_pkg::RANK_W-1:0]  rank_v   [NUM_ELEMENTS];
  logic [uf_pkg::CNT_W-1:0]   live_sets;

  uf_pkg::res_t due_results [$];
  uf_pkg::res_t want;
  uf_pkg::res_t got;
  int   fault_total = 0;
  int   checked_total = 0;
  int   error_total = 0;
  int   link_total = 0;
  int   walk_max = 0;

  function automatic bit is_live_root(input logic [uf_pkg::IDX_W-1:0] x);
    return int'(x) < NUM_ELEMENTS && made_v[x] && root_v[x];
  endfunction

  // Apply one operation to the shadow table and return the word it must produce.
  function automatic uf_pkg::res_t apply_dsu_op(input logic [uf_pkg::MODE_W-1:0] mode,
                                                input logic [uf_pkg::IDX_W-1:0]  a,
                                                input logic [uf_pkg::IDX_W-1:0]  b);
    uf_pkg::res_t r;
    int   win;
    int   lose;
    int   top;
    int   x;
    int   nxt;
    int   hops;
    r.result_index = a;
    r.status       = uf_pkg::ST_OK;
    r.set_size     = '0;
    case (mode)
      uf_pkg::MODE_MAKE: begin
        if (int'(a) >= NUM_ELEMENTS) begin
          r.status = uf_pkg::ST_NEVER_MADE;
        end else if (made_v[a]) begin
          r.status = uf_pkg::ST_MADE;
        end else begin
          made_v[a]   = 1'b1;
          root_v[a]   = 1'b1;
          size_v[a]   = uf_pkg::CNT_W'(1);
          rank_v[a]   = uf_pkg::RANK_W'(1);
          live_sets   = live_sets + uf_pkg::CNT_W'(1);
          r.set_size  = uf_pkg::CNT_W'(1);
        end
      end
      uf_pkg::MODE_UNION: begin
        if (!is_live_root(a) || !is_live_root(b)) begin
          r.status = uf_pkg::ST_NOT_ROOT;
        end else if (a == b) begin
          r.set_size = size_v[a];
        end else begin
          // lower rank hangs under higher; a tie goes to the first root
          if (rank_v[a] < rank_v[b]) begin
            win  = int'(b);
            lose = int'(a);
          end else begin
            win  = int'(a);
            lose = int'(b);
            if (rank_v[a] == rank_v[b] && rank_v[a] < uf_pkg::RANK_MAX)
              rank_v[a] = rank_v[a] + uf_pkg::RANK_W'(1);
          end
          root_v[lose]   = 1'b0;
          parent_v[lose] = uf_pkg::IDX_W'(win);
          size_v[win]    = size_v[win] + size_v[lose];
          live_sets      = live_sets - uf_pkg::CNT_W'(1);
          r.result_index = uf_pkg::IDX_W'(win);
          r.set_size     = size_v[win];
          link_total++;
        end
      end
      default: begin
        // find, with the spare mode code decoded the same way
        if (int'(a) >= NUM_ELEMENTS || !made_v[a]) begin
          r.status = uf_pkg::ST_NEVER_MADE;
        end else begin
          top  = int'(a);
          hops = 0;
          while (!root_v[top] && hops < NUM_ELEMENTS) begin
            nxt = int'(parent_v[top]);
            if (nxt >= NUM_ELEMENTS) break;
            top = nxt;
            hops++;
          end
          if (hops > walk_max) walk_max = hops;
          // flatten the path onto the root
          x    = int'(a);
          hops = 0;
          while (x != top && !root_v[x] && hops < NUM_ELEMENTS) begin
            nxt         = int'(parent_v[x]);
            parent_v[x] = uf_pkg::IDX_W'(top);
            if (nxt >= NUM_ELEMENTS) break;
            x = nxt;
            hops++;
          end
          r.result_index = uf_pkg::IDX_W'(top);
          r.set_size     = size_v[top];
        end
      end
    endcase
    r.set_count = live_sets;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      made_v    = '0;
      root_v    = '0;
      live_sets = '0;
      for (int i = 0; i < NUM_ELEMENTS; i++) begin
        parent_v[i] = '0;
        size_v[i]   = '0;
        rank_v[i]   = '0;
      end
      due_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        due_results.push_back(apply_dsu_op(s_tuser, s_tdata[uf_pkg::IDX_W-1:0],
                                           s_tdata[2*uf_pkg::IDX_W-1:uf_pkg::IDX_W]));
      if (m_tvalid && m_tready) begin
        got.result_index = m_tdata[uf_pkg::IDX_W-1:0];
        got.status       = uf_pkg::status_t'(m_tuser);
        got.set_count    = m_tdata[uf_pkg::IDX_W+uf_pkg::CNT_W-1:uf_pkg::IDX_W];
        got.set_size     = m_tdata[uf_pkg::IDX_W+2*uf_pkg::CNT_W-1:
                                   uf_pkg::IDX_W+uf_pkg::CNT_W];
        if (due_results.size() == 0) begin
          fault_total++;
          $error("result word with nothing outstanding: index %0d status %0d",
                 got.result_index, got.status);
        end else begin
          want = due_results.pop_front();
          checked_total++;
          if (want.status != uf_pkg::ST_OK) error_total++;
          if (got.result_index !== want.result_index) begin
            fault_total++;
            $error("result_index: expected %0d, got %0d", want.result_index,
                   got.result_index);
          end
          if (got.status !== want.status) begin
            fault_total++;
            $error("status: expected %0d, got %0d", want.status, got.status);
          end
          if (got.set_count !== want.set_count) begin
            fault_total++;
            $error("set_count: expected %0d, got %0d", want.set_count, got.set_count);
          end
          if (got.set_size !== want.set_size) begin
            fault_total++;
            $error("set_size: expected %0d, got %0d", want.set_size, got.set_size);
          end
        end
      end
    end
    mismatches    <= fault_total;
    outstanding   <= due_results.size();
    words_checked <= checked_total;
    error_words   <= error_total;
    links_made    <= link_total;
    deepest_walk  <= walk_max;
    made_mask     <= made_v;
    root_mask     <= root_v;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int ELEMENTS      = uf_pkg::NUM_ELEMENTS_DEF;
  localparam int RANDOM_WORDS  = 1800;
  localparam int CALM_WORDS    = 200;   // closing stretch with no idling
  localparam int SQUEEZE_AT    = 400;
  localparam int SQUEEZE_LEN   = 300;
  localparam int STALL_LIMIT   = 6000;  // covers the clearing pass and the long hold
  localparam int TAIL_CYCLES   = 40;
  localparam int PROBES        = 48;
  // spare mode code, which the block decodes as find
  localparam logic [uf_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // index_a[9:0], index_b[19:10], zero pad [23:20]
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // result_index[9:0], set_count[20:10], set_size[31:21]
  logic [1:0]  m_tuser;        // status[1:0]

  int                  mismatches;
  int                  outstanding;
  int                  words_checked;
  int                  error_words;
  int                  links_made;
  int                  deepest_walk;
  logic [ELEMENTS-1:0] made_mask;
  logic [ELEMENTS-1:0] root_mask;

  bit tx_stalls    = 1'b1;
  bit rx_stalls    = 1'b1;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;
  int words_sent   = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  union_find_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  union_find_checker #(.NUM_ELEMENTS(ELEMENTS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked),
    .error_words   (error_words),
    .links_made    (links_made),
    .deepest_walk  (deepest_walk),
    .made_mask     (made_mask),
    .root_mask     (root_mask)
  );

  // Offer one word and hold it until it is taken; an idle burst may come first.
  task automatic send_word(input logic [uf_pkg::MODE_W-1:0] mode,
                           input logic [uf_pkg::IDX_W-1:0] a,
                           input logic [uf_pkg::IDX_W-1:0] b);
    if (tx_stalls && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {{(24 - 2*uf_pkg::IDX_W){1'b0}}, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // Operand pickers probe the checker's registered view of the table; a pick that finds
  // no match after PROBES tries just turns into an error case.
  function automatic logic [uf_pkg::IDX_W-1:0] pick_root();
    logic [uf_pkg::IDX_W-1:0] x;
    for (int i = 0; i < PROBES; i++) begin
      x = uf_pkg::IDX_W'($urandom_range(0, ELEMENTS - 1));
      if (root_mask[x]) return x;
    end
    return x;
  endfunction

  function automatic logic [uf_pkg::IDX_W-1:0] pick_made();
    logic [uf_pkg::IDX_W-1:0] x;
    for (int i = 0; i < PROBES; i++) begin
      x = uf_pkg::IDX_W'($urandom_range(0, ELEMENTS - 1));
      if (made_mask[x]) return x;
    end
    return x;
  endfunction

  function automatic logic [uf_pkg::IDX_W-1:0] pick_fresh();
    logic [uf_pkg::IDX_W-1:0] x;
    for (int i = 0; i < PROBES; i++) begin
      x = uf_pkg::IDX_W'($urandom_range(0, ELEMENTS - 1));
      if (!made_mask[x]) return x;
    end
    return x;
  endfunction

  // Result side: ready bursts, random stalls, and one long hold on request.
  initial begin
    forever begin
      if (squeeze_req && !squeeze_done) begin
        m_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk);
        squeeze_done = 1'b1;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, outstanding);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int                        roll;
    logic [uf_pkg::IDX_W-1:0]  ra;
    logic [uf_pkg::IDX_W-1:0]  rb;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: error paths, rank ties and wins, path compression, field extremes
    send_word(uf_pkg::MODE_FIND, 0, 0);           // find on an element never made
    send_word(uf_pkg::MODE_UNION, 0, 1023);       // union of never-made operands
    send_word(uf_pkg::MODE_MAKE, 0, 0);
    send_word(uf_pkg::MODE_MAKE, 1023, 0);
    send_word(uf_pkg::MODE_MAKE, 0, 0);           // already made
    send_word(uf_pkg::MODE_MAKE, 1, 0);
    send_word(uf_pkg::MODE_MAKE, 2, 0);
    send_word(uf_pkg::MODE_MAKE, 3, 0);
    send_word(uf_pkg::MODE_MAKE, 4, 0);
    send_word(uf_pkg::MODE_UNION, 0, 0);          // root with itself
    send_word(uf_pkg::MODE_UNION, 0, 1);          // tie: first root wins
    send_word(uf_pkg::MODE_UNION, 2, 3);
    send_word(uf_pkg::MODE_UNION, 1, 2);          // first operand no longer a root
    send_word(uf_pkg::MODE_UNION, 4, 0);          // lower rank goes under, second wins
    send_word(uf_pkg::MODE_UNION, 2, 0);          // tie at higher rank
    send_word(uf_pkg::MODE_FIND, 1, 0);           // two-hop walk, then compressed
    send_word(uf_pkg::MODE_FIND, 1, 0);
    send_word(uf_pkg::MODE_FIND, 4, 0);
    send_word(MODE_SPARE, 1023, 0);               // spare mode acts as find
    send_word(MODE_SPARE, 512, 0);
    send_word(uf_pkg::MODE_UNION, 1023, 2);
    send_word(uf_pkg::MODE_FIND, 3, 1023);        // ignored operand at its maximum
    send_word(uf_pkg::MODE_MAKE, 1023, 1023);
    send_word(uf_pkg::MODE_UNION, 3, 1023);       // neither operand a root any more
    send_word(uf_pkg::MODE_UNION, 2, 2);

    // random: mostly well-formed operations on live elements, some noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == SQUEEZE_AT) squeeze_req = 1'b1;
      if (n == RANDOM_WORDS - CALM_WORDS) begin
        tx_stalls = 1'b0;
        rx_stalls = 1'b0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
        send_word(uf_pkg::MODE_MAKE, pick_fresh(), uf_pkg::IDX_W'($urandom));
      end else if (roll < 55) begin
        ra = pick_root();
        rb = ($urandom_range(0, 19) == 0) ? ra : pick_root();
        send_word(uf_pkg::MODE_UNION, ra, rb);
      end else if (roll < 88) begin
        send_word(($urandom_range(0, 9) == 0) ? MODE_SPARE : uf_pkg::MODE_FIND,
                  pick_made(), uf_pkg::IDX_W'($urandom));
      end else begin
        send_word(uf_pkg::MODE_W'($urandom_range(0, 3)), uf_pkg::IDX_W'($urandom),
                  uf_pkg::IDX_W'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("coverage: %0d words in, %0d results checked, %0d of them error statuses",
             words_sent, words_checked, error_words);
    $display("coverage: %0d sets linked, deepest find walk %0d hops, one %0d-cycle hold",
             links_made, deepest_walk, SQUEEZE_LEN);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
